### src/smba_pkg.sv
// shared types and constants for the slot map block allocator
package smba_pkg;

   localparam int FUNC_BITS    = 2;
   localparam int KEY_IN_BITS  = 16;
   localparam int LEN_BITS     = 13;
   localparam int ANCHOR_BITS  = 16;
   localparam int STATUS_BITS  = 2;
   localparam int LB_BITS      = 12;
   localparam int BS_BITS      = 13;
   localparam int CSR_IDX_BITS = 1;
   // signed width that holds anchor, slot count and anchor minus length
   localparam int CALC_BITS    = 18;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_EXACT    = 2'd0,
      FUNC_BACKWARD = 2'd1,
      FUNC_FORWARD  = 2'd2,
      FUNC_READ     = 2'd3
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_COMPLETE = 2'd0,
      STATUS_PARTIAL  = 2'd1,
      STATUS_OUTSIDE  = 2'd2
   } status_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LOWER_BOUND = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCK_SIZE  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_EXACT,
      ST_SCAN,
      ST_WRITE,
      ST_READ,
      ST_DONE
   } state_type;

endpackage

### src/smba_ram.sv
// slot map storage: one write port, one registered read port
module smba_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16,
   parameter int AW    = 12
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/slot_map_block_allocator_core.sv
// slot map block allocator: exact, backward and forward fills and slot reads
// an exact fill writes each slot of its interval in turn; a read fetches one slot key
// searching fills scan slot by slot and then write back each free run they claim,
// walking the slot memory (one write port, one registered read port) with the sequencer
// one transaction at a time; a finished result waits in the output register meanwhile
// reset is synchronous; afterwards a clearing pass frees every slot
// before the first transaction is accepted
module slot_map_block_allocator_core #(
   parameter int SLOTS    = 4096,
   parameter int KEY_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [smba_pkg::FUNC_BITS-1:0]     req_func,
   input  logic [smba_pkg::KEY_IN_BITS-1:0]   req_owner_key,
   input  logic [smba_pkg::LEN_BITS-1:0]      req_length,
   input  logic [smba_pkg::ANCHOR_BITS-1:0]   req_anchor,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [smba_pkg::LEN_BITS-1:0]      rsp_placed,
   output logic [smba_pkg::KEY_IN_BITS-1:0]   rsp_slot_key,
   output logic [smba_pkg::STATUS_BITS-1:0]   rsp_status,
   input  logic                               csr_we,
   input  logic [smba_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [smba_pkg::BS_BITS-1:0]       csr_wdata
);

   import smba_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam int PW = AW + 2;
   localparam logic signed [PW-1:0]        P_SLOTS = PW'(SLOTS);
   localparam logic signed [PW-1:0]        P_ONE   = PW'(1);
   localparam logic signed [CALC_BITS-1:0] C_SLOTS = CALC_BITS'(SLOTS);

   state_type               state_ff, state_in;
   logic signed [PW-1:0]    pos_ff, pos_in;
   logic signed [PW-1:0]    end_ff, end_in;
   logic [AW-1:0]           wptr_ff, wptr_in;
   logic [LEN_BITS-1:0]     wcnt_ff, wcnt_in;
   logic [LEN_BITS-1:0]     run_ff, run_in;
   logic [LEN_BITS-1:0]     rem_ff, rem_in;
   logic [LEN_BITS-1:0]     placed_ff, placed_in;
   logic                    oor_ff, oor_in;
   logic [KEY_BITS-1:0]     rkey_ff, rkey_in;
   logic [LB_BITS-1:0]      lb_ff;
   logic [BS_BITS-1:0]      bs_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   func_type                func_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic [LEN_BITS-1:0]     length_ff;
   logic [ANCHOR_BITS-1:0]  anchor_ff;
   logic [LEN_BITS-1:0]     rsp_placed_ff;
   logic [KEY_IN_BITS-1:0]  rsp_slot_key_ff;
   logic [STATUS_BITS-1:0]  rsp_status_ff;

   logic                    req_accept;
   logic                    rsp_load;
   status_type              status_c;

   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [KEY_BITS-1:0]     mem_wdata;
   logic [KEY_BITS-1:0]     mem_rdata;

   logic signed [CALC_BITS-1:0] pos_ext, lb_ext, anchor_ext, diff_c;
   logic signed [CALC_BITS-1:0] s0_c, s1_c, end_c, start_c, fwd_c;
   logic [BS_BITS-1:0]      bsize_c;
   logic [LEN_BITS-1:0]     grab_c;
   logic                    backward;
   logic signed [PW-1:0]    pos_step;
   logic                    scan_stop;

   smba_ram #(
      .DEPTH (SLOTS),
      .WIDTH (KEY_BITS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (pos_in[AW-1:0]),
      .rd_data (mem_rdata)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // exact interval bounds, search start points, and the scan step, claim size and stop test
   always_comb begin
      pos_ext    = CALC_BITS'(pos_ff);
      lb_ext     = signed'(CALC_BITS'(lb_ff));
      anchor_ext = signed'(CALC_BITS'(anchor_ff));
      diff_c     = anchor_ext - signed'(CALC_BITS'(length_ff));
      s0_c       = diff_c[CALC_BITS-1] ? '0 : diff_c;
      s1_c       = (s0_c < lb_ext) ? lb_ext : s0_c;
      end_c      = (anchor_ext > C_SLOTS) ? C_SLOTS : anchor_ext;
      start_c    = (s1_c < end_c) ? s1_c : end_c;
      fwd_c      = (lb_ext < C_SLOTS) ? lb_ext : C_SLOTS;
      bsize_c    = (bs_ff == '0) ? BS_BITS'(1) : bs_ff;
      grab_c     = (rem_ff < bsize_c) ? rem_ff : bsize_c;
      backward   = (func_ff == FUNC_BACKWARD);
      pos_step   = backward ? (pos_ff - P_ONE) : (pos_ff + P_ONE);
      scan_stop  = (rem_ff == '0) ||
                   (backward ? (pos_ext < lb_ext) : (pos_ext >= C_SLOTS));
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      wptr_in      = wptr_ff;
      wcnt_in      = wcnt_ff;
      run_in       = run_ff;
      rem_in       = rem_ff;
      placed_in    = placed_ff;
      oor_in       = oor_ff;
      rkey_in      = rkey_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_load     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff[AW-1:0];
      mem_wdata    = key_ff;
      status_c     = STATUS_COMPLETE;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            if (pos_ff == P_SLOTS - P_ONE) begin
               pos_in   = '0;
               state_in = ST_IDLE;
            end else begin
               pos_in = pos_ff + P_ONE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               placed_in = '0;
               run_in    = '0;
               rkey_in   = '0;
               oor_in    = 1'b0;
               rem_in    = req_length;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            unique case (func_ff)
               FUNC_EXACT: begin
                  oor_in   = (anchor_ext > C_SLOTS);
                  pos_in   = PW'(start_c);
                  end_in   = PW'(end_c);
                  state_in = ST_EXACT;
               end
               FUNC_BACKWARD: begin
                  if (anchor_ext >= C_SLOTS) begin
                     oor_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     pos_in   = PW'(anchor_ext);
                     state_in = ST_SCAN;
                  end
               end
               FUNC_FORWARD: begin
                  pos_in   = PW'(fwd_c);
                  state_in = ST_SCAN;
               end
               FUNC_READ: begin
                  if (anchor_ext >= C_SLOTS) begin
                     oor_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     pos_in   = PW'(anchor_ext);
                     state_in = ST_READ;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_EXACT: begin
            if (pos_ff < end_ff) begin
               mem_we    = 1'b1;
               pos_in    = pos_ff + P_ONE;
               placed_in = placed_ff + LEN_BITS'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            // read data here is the slot at pos_ff
            if (scan_stop) begin
               state_in = ST_DONE;
            end else if (mem_rdata != '0) begin
               run_in = '0;
               pos_in = pos_step;
            end else if ((run_ff + LEN_BITS'(1)) == grab_c) begin
               // free run complete: claim it walking back from this slot
               wptr_in  = pos_ff[AW-1:0];
               wcnt_in  = grab_c;
               run_in   = '0;
               pos_in   = pos_step;
               state_in = ST_WRITE;
            end else begin
               run_in = run_ff + LEN_BITS'(1);
               pos_in = pos_step;
            end
         end
         ST_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = wptr_ff;
            wptr_in   = backward ? (wptr_ff + AW'(1)) : (wptr_ff - AW'(1));
            wcnt_in   = wcnt_ff - LEN_BITS'(1);
            rem_in    = rem_ff - LEN_BITS'(1);
            placed_in = placed_ff + LEN_BITS'(1);
            if (wcnt_ff == LEN_BITS'(1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_READ: begin
            rkey_in  = mem_rdata;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (oor_ff) begin
               status_c = STATUS_OUTSIDE;
            end else if (func_ff != FUNC_READ && placed_ff < length_ff) begin
               status_c = STATUS_PARTIAL;
            end
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pos_ff       <= '0;
         end_ff       <= '0;
         wptr_ff      <= '0;
         wcnt_ff      <= '0;
         run_ff       <= '0;
         rem_ff       <= '0;
         placed_ff    <= '0;
         oor_ff       <= 1'b0;
         rkey_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         lb_ff        <= '0;
         bs_ff        <= BS_BITS'(1);
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         end_ff       <= end_in;
         wptr_ff      <= wptr_in;
         wcnt_ff      <= wcnt_in;
         run_ff       <= run_in;
         rem_ff       <= rem_in;
         placed_ff    <= placed_in;
         oor_ff       <= oor_in;
         rkey_ff      <= rkey_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOWER_BOUND: lb_ff <= csr_wdata[LB_BITS-1:0];
               CSR_BLOCK_SIZE:  bs_ff <= csr_wdata;
               default:         bs_ff <= bs_ff;
            endcase
         end
      end
   end

   // transaction payload and result registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff   <= func_type'(req_func);
         key_ff    <= KEY_BITS'(req_owner_key);
         length_ff <= req_length;
         anchor_ff <= req_anchor;
      end
      if (rsp_load) begin
         rsp_placed_ff   <= placed_ff;
         rsp_slot_key_ff <= KEY_IN_BITS'(rkey_ff);
         rsp_status_ff   <= status_c;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_placed   = rsp_placed_ff;
   assign rsp_slot_key = rsp_slot_key_ff;
   assign rsp_status   = rsp_status_ff;

`ifndef SYNTHESIS
   // while scanning or writing, slots claimed plus slots still wanted add up to the request
   a_rem_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_WRITE) |-> (rem_ff + placed_ff == length_ff))
      else $error("remaining and placed counts out of balance");

   a_placed_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (placed_ff <= length_ff))
      else $error("more slots placed than requested");

   a_claim_in_map: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> ((AW+1)'(wptr_ff) < (AW+1)'(SLOTS)))
      else $error("claim write outside the slot map");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   a_run_below_grab: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !scan_stop) |-> (run_ff < grab_c))
      else $error("free run counter passed the claim size");
`endif

endmodule
